[hdl/ffp_pkg.sv]
`default_nettype none
package ffp_pkg;

    localparam int MAX_PAIRS = 32;
    localparam int KEY_MAX   = 31;
    localparam int VALUE_MAX = 255;

    localparam int PAIR_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int KLEN_W = $clog2(KEY_MAX + 1);
    localparam int VAL_W  = $clog2(VALUE_MAX + 1);
    localparam int CC_W   = (KLEN_W > VAL_W) ? KLEN_W : VAL_W;
    localparam int KS_AW  = PAIR_W + KLEN_W;

    localparam logic [7:0] CH_PCT = 8'h25;
    localparam logic [7:0] CH_EQ  = 8'h3d;
    localparam logic [7:0] CH_NL  = 8'h0a;
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_DEL = 8'h7f;

    localparam logic [2:0] K_NONE   = 3'd0;
    localparam logic [2:0] K_KEY    = 3'd1;
    localparam logic [2:0] K_VALUE  = 3'd2;
    localparam logic [2:0] K_PAIR   = 3'd3;
    localparam logic [2:0] K_ACCEPT = 3'd4;
    localparam logic [2:0] K_REJECT = 3'd5;

    localparam logic [3:0] E_NONE     = 4'd0;
    localparam logic [3:0] E_KEY_CHAR = 4'd1;
    localparam logic [3:0] E_KEY_LONG = 4'd2;
    localparam logic [3:0] E_KEY_NONE = 4'd3;
    localparam logic [3:0] E_DUP      = 4'd4;
    localparam logic [3:0] E_ESCAPE   = 4'd5;
    localparam logic [3:0] E_VAL_CHAR = 4'd6;
    localparam logic [3:0] E_VAL_LONG = 4'd7;
    localparam logic [3:0] E_TOO_MANY = 4'd8;
    localparam logic [3:0] E_TRUNC    = 4'd9;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [2:0] out_kind;
        logic [7:0] out_char;
        logic [4:0] pair_index;
        logic [5:0] pair_total;
        logic [3:0] error_code;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  pairs;
        logic [KLEN_W-1:0] cnt;
        logic              key_we;
        logic [KLEN_W-1:0] key_idx;
        logic [7:0]        key_char;
        logic              len_we;
    } t_km_ctl;

    typedef struct packed {
        logic done;
        logic hit;
    } t_km_sts;

    // {valid, nibble}
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic key_char_ok(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h30 && b <= 8'h39) || (b == 8'h5f);
    endfunction

endpackage
`default_nettype wire

[hdl/ffp_ram.sv]
`default_nettype none
module ffp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[hdl/ffp_keymatch.sv]
`default_nettype none
module ffp_keymatch (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ffp_pkg::t_km_ctl i_ctl,
    output ffp_pkg::t_km_sts     o_sts
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_LEN  = 4'b0010,
        M_ADDR = 4'b0100,
        M_CMP  = 4'b1000
    } t_mstate;

    t_mstate                         r_state;
    logic [ffp_pkg::CNT_W-1:0]       r_j;
    logic [ffp_pkg::KLEN_W-1:0]      r_k;
    logic [ffp_pkg::CNT_W-1:0]       r_pairs;
    logic [ffp_pkg::KLEN_W-1:0]      r_cnt;
    logic [ffp_pkg::KLEN_W-1:0]      r_len [ffp_pkg::MAX_PAIRS];
    logic [7:0]                      r_cur [2**ffp_pkg::KLEN_W];
    logic [7:0]                      w_rdata;
    logic [ffp_pkg::PAIR_W-1:0]      w_jix;
    logic                            w_end;
    logic                            w_len_eq;
    logic                            w_ch_eq;
    logic                            w_last;

    assign w_jix    = r_j[ffp_pkg::PAIR_W-1:0];
    assign w_end    = (r_j == r_pairs);
    assign w_len_eq = (r_len[w_jix] == r_cnt);
    assign w_ch_eq  = (w_rdata == r_cur[r_k]);
    assign w_last   = ((r_k + ffp_pkg::KLEN_W'(1)) == r_cnt);

    ffp_ram #(
        .WIDTH(8),
        .DEPTH(1 << ffp_pkg::KS_AW)
    ) u_key_store (
        .i_clk  (i_clk),
        .i_we   (i_ctl.key_we),
        .i_waddr({i_ctl.pairs[ffp_pkg::PAIR_W-1:0], i_ctl.key_idx}),
        .i_wdata(i_ctl.key_char),
        .i_raddr({w_jix, r_k}),
        .o_rdata(w_rdata)
    );

    always_comb begin
        o_sts.done = 1'b0;
        o_sts.hit  = 1'b0;
        if (r_state == M_LEN && w_end) begin
            o_sts.done = 1'b1;
        end else if (r_state == M_CMP && w_ch_eq && w_last) begin
            o_sts.done = 1'b1;
            o_sts.hit  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.key_we) begin
            r_cur[i_ctl.key_idx] <= i_ctl.key_char;
        end
        if (i_ctl.len_we) begin
            r_len[i_ctl.pairs[ffp_pkg::PAIR_W-1:0]] <= i_ctl.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            unique case (r_state)
                M_IDLE: begin
                    if (i_ctl.start) begin
                        r_j     <= '0;
                        r_pairs <= i_ctl.pairs;
                        r_cnt   <= i_ctl.cnt;
                        r_state <= M_LEN;
                    end
                end
                M_LEN: begin
                    if (w_end) begin
                        r_state <= M_IDLE;
                    end else if (!w_len_eq) begin
                        r_j <= r_j + ffp_pkg::CNT_W'(1);
                    end else begin
                        r_k     <= '0;
                        r_state <= M_ADDR;
                    end
                end
                M_ADDR: begin
                    r_state <= M_CMP;
                end
                M_CMP: begin
                    if (!w_ch_eq) begin
                        r_j     <= r_j + ffp_pkg::CNT_W'(1);
                        r_state <= M_LEN;
                    end else if (w_last) begin
                        r_state <= M_IDLE;
                    end else begin
                        r_k     <= r_k + ffp_pkg::KLEN_W'(1);
                        r_state <= M_ADDR;
                    end
                end
                default: r_state <= M_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[hdl/form_field_parser.sv]
// Each request is registered in r_item, processed in S_EXEC and its result registered in
// r_out; the next request is taken only back in S_IDLE. A key-closing '=' runs the
// duplicate-key search: it checks each stored key's length and compares characters only
// with keys of equal length, stopping on a duplicate. A stalled result holds off the input.
// Reset (synchronous, active low) clears control state and the message; the key store
// and key lengths hold no reset value and need no clearing pass.
`default_nettype none
module form_field_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ffp_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ffp_pkg::t_out      o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DUP  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    typedef enum logic [4:0] {
        PH_KEY       = 5'b00001,
        PH_VALUE     = 5'b00010,
        PH_ESC_FIRST = 5'b00100,
        PH_ESC_GOOD  = 5'b01000,
        PH_ESC_BAD   = 5'b10000
    } t_phase;

    t_state                     r_state;
    t_phase                     r_phase, n_phase;
    logic [ffp_pkg::CNT_W-1:0]  r_pairs, n_pairs;
    logic [ffp_pkg::CC_W-1:0]   r_cc, n_cc;
    logic [3:0]                 r_hi, n_hi;
    logic [3:0]                 r_err, n_err;
    ffp_pkg::t_in               r_item;
    ffp_pkg::t_out              r_out, n_out;
    logic                       r_out_valid;
    logic                       r_hit;
    logic                       w_need_dup;
    logic                       w_key_we;
    logic                       w_out_free;
    logic                       w_out_load;
    logic [4:0]                 w_nib;
    logic [7:0]                 w_vc;
    logic                       w_vc_en;
    logic [7:0]                 w_pairs8;
    logic [3:0]                 w_end_err;
    ffp_pkg::t_km_ctl           w_km_ctl;
    ffp_pkg::t_km_sts           w_km_sts;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_out_load  = w_out_free && ((r_state == S_EXEC && !w_need_dup) || r_state == S_FIN);
    assign w_pairs8    = 8'(r_pairs);
    assign w_nib       = ffp_pkg::hex_nibble(r_item.data_byte);

    always_comb begin
        n_phase    = r_phase;
        n_pairs    = r_pairs;
        n_cc       = r_cc;
        n_hi       = r_hi;
        n_err      = r_err;
        n_out      = '0;
        w_need_dup = 1'b0;
        w_key_we   = 1'b0;
        w_vc       = r_item.data_byte;
        w_vc_en    = 1'b0;
        w_end_err  = r_err;
        if (r_item.kind == ffp_pkg::KIND_END) begin
            if (r_err == ffp_pkg::E_NONE && !(r_phase == PH_KEY && r_cc == '0)) begin
                w_end_err = ffp_pkg::E_TRUNC;
            end
            n_out.out_kind   = (w_end_err != ffp_pkg::E_NONE) ? ffp_pkg::K_REJECT
                                                                : ffp_pkg::K_ACCEPT;
            n_out.pair_total = w_pairs8[5:0];
            n_out.error_code = w_end_err;
            n_phase = PH_KEY;
            n_pairs = '0;
            n_cc    = '0;
            n_hi    = '0;
            n_err   = ffp_pkg::E_NONE;
        end else if (r_err == ffp_pkg::E_NONE) begin
            unique case (r_phase)
                PH_KEY: begin
                    if (r_cc == '0 && r_pairs >= ffp_pkg::CNT_W'(ffp_pkg::MAX_PAIRS)) begin
                        n_err = ffp_pkg::E_TOO_MANY;
                    end else if (r_item.data_byte == ffp_pkg::CH_EQ) begin
                        if (r_cc == '0) begin
                            n_err = ffp_pkg::E_KEY_NONE;
                        end else begin
                            w_need_dup = 1'b1;
                        end
                    end else if (r_cc >= ffp_pkg::CC_W'(ffp_pkg::KEY_MAX)) begin
                        n_err = ffp_pkg::E_KEY_LONG;
                    end else if (!ffp_pkg::key_char_ok(r_item.data_byte)) begin
                        n_err = ffp_pkg::E_KEY_CHAR;
                    end else begin
                        w_key_we         = 1'b1;
                        n_cc             = r_cc + ffp_pkg::CC_W'(1);
                        n_out.out_kind   = ffp_pkg::K_KEY;
                        n_out.out_char   = r_item.data_byte;
                        n_out.pair_index = w_pairs8[4:0];
                    end
                end
                PH_VALUE: begin
                    if (r_item.data_byte == ffp_pkg::CH_NL) begin
                        n_out.out_kind   = ffp_pkg::K_PAIR;
                        n_out.pair_index = w_pairs8[4:0];
                        n_pairs          = r_pairs + ffp_pkg::CNT_W'(1);
                        n_cc             = '0;
                        n_phase          = PH_KEY;
                    end else if (r_item.data_byte == ffp_pkg::CH_PCT) begin
                        n_phase = PH_ESC_FIRST;
                    end else begin
                        w_vc_en = 1'b1;
                    end
                end
                PH_ESC_FIRST: begin
                    if (w_nib[4]) begin
                        n_hi    = w_nib[3:0];
                        n_phase = PH_ESC_GOOD;
                    end else begin
                        n_phase = PH_ESC_BAD;
                    end
                end
                PH_ESC_GOOD: begin
                    if (!w_nib[4]) begin
                        n_err = ffp_pkg::E_ESCAPE;
                    end else begin
                        n_phase = PH_VALUE;
                        w_vc    = {r_hi, w_nib[3:0]};
                        w_vc_en = 1'b1;
                    end
                end
                default: begin
                    n_err = ffp_pkg::E_ESCAPE;
                end
            endcase
            if (w_vc_en) begin
                if (w_vc < ffp_pkg::CH_SP || w_vc == ffp_pkg::CH_DEL) begin
                    n_err = ffp_pkg::E_VAL_CHAR;
                end else if (r_cc >= ffp_pkg::CC_W'(ffp_pkg::VALUE_MAX)) begin
                    n_err = ffp_pkg::E_VAL_LONG;
                end else begin
                    n_cc             = r_cc + ffp_pkg::CC_W'(1);
                    n_out.out_kind   = ffp_pkg::K_VALUE;
                    n_out.out_char   = w_vc;
                    n_out.pair_index = w_pairs8[4:0];
                end
            end
        end
    end

    always_comb begin
        w_km_ctl.start    = (r_state == S_EXEC) && w_need_dup;
        w_km_ctl.pairs    = r_pairs;
        w_km_ctl.cnt      = r_cc[ffp_pkg::KLEN_W-1:0];
        w_km_ctl.key_we   = (r_state == S_EXEC) && !w_need_dup && w_out_free && w_key_we;
        w_km_ctl.key_idx  = r_cc[ffp_pkg::KLEN_W-1:0];
        w_km_ctl.key_char = r_item.data_byte;
        w_km_ctl.len_we   = (r_state == S_FIN) && w_out_free && !r_hit;
    end

    ffp_keymatch u_keymatch (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_km_ctl),
        .o_sts  (w_km_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_KEY;
            r_pairs     <= '0;
            r_cc        <= '0;
            r_hi        <= '0;
            r_err       <= ffp_pkg::E_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_out_load || (r_out_valid && i_out_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_need_dup) begin
                        r_state <= S_DUP;
                    end else if (w_out_free) begin
                        r_phase     <= n_phase;
                        r_pairs     <= n_pairs;
                        r_cc        <= n_cc;
                        r_hi        <= n_hi;
                        r_err       <= n_err;
                        r_out       <= n_out;
                        r_state     <= S_IDLE;
                    end
                end
                S_DUP: begin
                    if (w_km_sts.done) begin
                        r_hit   <= w_km_sts.hit;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        if (r_hit) begin
                            r_err <= ffp_pkg::E_DUP;
                        end else begin
                            r_cc    <= '0;
                            r_phase <= PH_VALUE;
                        end
                        r_out       <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

[hdl/ffp_checker.sv]
`default_nettype none
module ffp_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_stall,
    input wire ffp_pkg::t_in  i_in_data,
    input wire logic          o_out_valid,
    input wire logic          i_out_stall,
    input wire ffp_pkg::t_out o_out_data
);

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    a_code_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.out_kind == ffp_pkg::K_REJECT)
                         == (o_out_data.error_code != ffp_pkg::E_NONE)))
        else $error("error code does not match verdict");

    a_verdict_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.out_kind == ffp_pkg::K_ACCEPT
                         || o_out_data.out_kind == ffp_pkg::K_REJECT))
        |-> (o_out_data.out_char == 8'd0 && o_out_data.pair_index == 5'd0))
        else $error("verdict carries character fields");

    a_total_only_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.out_kind != ffp_pkg::K_ACCEPT
                     && o_out_data.out_kind != ffp_pkg::K_REJECT)
        |-> (o_out_data.pair_total == 6'd0))
        else $error("pair total outside verdict");

endmodule

bind form_field_parser ffp_checker u_ffp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out_data (o_out_data)
);
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import ffp_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 150;

    typedef enum logic [2:0] {PS_KEY, PS_VALUE, PS_ESC_HI, PS_ESC_LO, PS_ESC_BAD} parse_state_e;
    typedef enum int {RX_FREE, RX_PATTERN, RX_LIGHT, RX_HEAVY} rx_mode_e;
    typedef enum int {
        F_KEY_CHAR, F_KEY_LONG, F_KEY_EMPTY, F_KEY_DUP, F_ESC_HI, F_ESC_LO,
        F_RAW_CTL, F_ESC_CTL, F_CUT, F_NOISE, F_KEY_NL
    } fault_e;

    typedef struct packed {
        logic [255:0] text;
        logic [5:0]   len;
    } key_t;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    t_in  i_in_data   = '0;
    logic i_out_stall = 1'b0;
    logic o_in_stall;
    logic o_out_valid;
    t_out o_out_data;

    form_field_parser DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #6 i_clk = ~i_clk;

    // parser state as the block should hold it
    parse_state_e pstate = PS_KEY;
    logic [7:0]   seen_keys [MAX_PAIRS][KEY_MAX+1];
    int           seen_len  [MAX_PAIRS];
    int           pair_cnt    = 0;
    int           char_cnt    = 0;
    logic [3:0]   esc_hi      = '0;
    logic [3:0]   err_latched = E_NONE;

    t_out pending_results [$];
    t_in  body_bytes [$];
    key_t used_keys [$];
    int   mismatches   = 0;
    int   items_sent   = 0;
    int   burst_left   = 0;
    int   quiet_cycles = 0;
    bit   hold_req     = 1'b0;

    function automatic int hex_of(logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - int'("0");
        if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
        if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
        return -1;
    endfunction

    function automatic bit is_key_char(logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "0" && b <= "9") || b == "_";
    endfunction

    function automatic bit key_clash();
        bit same;
        for (int j = 0; j < pair_cnt; j++) begin
            if (seen_len[j] == char_cnt) begin
                same = 1'b1;
                for (int c = 0; c < char_cnt; c++)
                    if (seen_keys[j][c] != seen_keys[pair_cnt][c]) same = 1'b0;
                if (same) return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic t_out take_value_char(logic [7:0] c);
        t_out r = '0;
        if (c < CH_SP || c == CH_DEL) begin
            err_latched = E_VAL_CHAR;
        end else if (char_cnt >= VALUE_MAX) begin
            err_latched = E_VAL_LONG;
        end else begin
            char_cnt++;
            r.out_kind   = K_VALUE;
            r.out_char   = c;
            r.pair_index = 5'(pair_cnt);
        end
        return r;
    endfunction

    function automatic t_out parse_byte(t_in it);
        t_out       r;
        logic [7:0] b;
        int         nib;
        r = '0;
        b = it.data_byte;
        if (it.kind == KIND_END) begin
            r.error_code = err_latched;
            if (r.error_code == E_NONE && !(pstate == PS_KEY && char_cnt == 0))
                r.error_code = E_TRUNC;
            r.out_kind   = (r.error_code == E_NONE) ? K_ACCEPT : K_REJECT;
            r.pair_total = 6'(pair_cnt);
            pstate      = PS_KEY;
            pair_cnt    = 0;
            char_cnt    = 0;
            esc_hi      = '0;
            err_latched = E_NONE;
            return r;
        end
        if (err_latched != E_NONE) return r;
        case (pstate)
            PS_KEY: begin
                if (char_cnt == 0 && pair_cnt >= MAX_PAIRS) begin
                    err_latched = E_TOO_MANY;
                end else if (b == CH_EQ) begin
                    if (char_cnt == 0) begin
                        err_latched = E_KEY_NONE;
                    end else if (key_clash()) begin
                        err_latched = E_DUP;
                    end else begin
                        seen_len[pair_cnt] = char_cnt;
                        char_cnt = 0;
                        pstate   = PS_VALUE;
                    end
                end else if (char_cnt >= KEY_MAX) begin
                    err_latched = E_KEY_LONG;
                end else if (!is_key_char(b)) begin
                    err_latched = E_KEY_CHAR;
                end else begin
                    seen_keys[pair_cnt][char_cnt] = b;
                    char_cnt++;
                    r.out_kind   = K_KEY;
                    r.out_char   = b;
                    r.pair_index = 5'(pair_cnt);
                end
            end
            PS_VALUE: begin
                if (b == CH_NL) begin
                    r.out_kind   = K_PAIR;
                    r.pair_index = 5'(pair_cnt);
                    pair_cnt++;
                    char_cnt = 0;
                    pstate   = PS_KEY;
                end else if (b == CH_PCT) begin
                    pstate = PS_ESC_HI;
                end else begin
                    r = take_value_char(b);
                end
            end
            PS_ESC_HI: begin
                nib = hex_of(b);
                if (nib < 0) begin
                    pstate = PS_ESC_BAD;
                end else begin
                    esc_hi = 4'(nib);
                    pstate = PS_ESC_LO;
                end
            end
            PS_ESC_LO: begin
                nib = hex_of(b);
                if (nib < 0) begin
                    err_latched = E_ESCAPE;
                end else begin
                    pstate = PS_VALUE;
                    r = take_value_char({esc_hi, 4'(nib)});
                end
            end
            default: err_latched = E_ESCAPE;
        endcase
        return r;
    endfunction

    function automatic void check_result(t_out got, t_out want);
        if (got.out_kind !== want.out_kind) begin
            $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
            mismatches++;
        end
        if (got.out_char !== want.out_char) begin
            $error("out_char: expected %0d, got %0d", want.out_char, got.out_char);
            mismatches++;
        end
        if (got.pair_index !== want.pair_index) begin
            $error("pair_index: expected %0d, got %0d", want.pair_index, got.pair_index);
            mismatches++;
        end
        if (got.pair_total !== want.pair_total) begin
            $error("pair_total: expected %0d, got %0d", want.pair_total, got.pair_total);
            mismatches++;
        end
        if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            mismatches++;
        end
    endfunction

    // message building
    function automatic void put(logic [7:0] b);
        t_in it;
        it.kind      = KIND_BYTE;
        it.data_byte = b;
        body_bytes.push_back(it);
    endfunction

    function automatic void put_end();
        t_in it;
        it.kind      = KIND_END;
        it.data_byte = 8'($urandom);
        body_bytes.push_back(it);
        used_keys.delete();
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) put(s[i]);
    endfunction

    function automatic logic [7:0] key_char_at(int i);
        if (i < 26) return 8'("a" + i);
        if (i < 36) return 8'("0" + i - 26);
        return "_";
    endfunction

    function automatic logic [7:0] rand_key_char();
        return key_char_at($urandom_range(0, 36));
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 10) return 8'("0" + n);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 10);
    endfunction

    function automatic logic [7:0] non_key_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (is_key_char(b) || b == CH_EQ);
        return b;
    endfunction

    function automatic logic [7:0] non_hex_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (hex_of(b) >= 0);
        return b;
    endfunction

    function automatic logic [7:0] rand_value_char();
        if ($urandom_range(0, 1)) return 8'($urandom_range(32, 126));
        return 8'($urandom_range(128, 255));
    endfunction

    // control character or DEL; a raw newline would close the value
    function automatic logic [7:0] bad_value_char(bit escaped);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 32)); while (!escaped && b == CH_NL);
        if (b == CH_SP) b = CH_DEL;
        return b;
    endfunction

    function automatic void put_value_char(logic [7:0] c, bit escaped);
        if (escaped || c == CH_PCT) begin
            put(CH_PCT);
            put(hex_char(c[7:4]));
            put(hex_char(c[3:0]));
        end else begin
            put(c);
        end
    endfunction

    function automatic void put_value(int len);
        repeat (len) put_value_char(rand_value_char(), $urandom_range(0, 4) == 0);
    endfunction

    // one byte per character, no escapes
    function automatic void put_plain_value(int len);
        logic [7:0] c;
        repeat (len) begin
            do c = rand_value_char(); while (c == CH_PCT);
            put(c);
        end
    endfunction

    function automatic int key_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, KEY_MAX) : $urandom_range(1, 6);
    endfunction

    function automatic int value_len();
        return ($urandom_range(0, 23) == 0) ? $urandom_range(0, VALUE_MAX) : $urandom_range(0, 8);
    endfunction

    function automatic key_t fresh_key(int len);
        key_t k;
        bit   clash;
        do begin
            k      = '0;
            k.len  = 6'(len);
            for (int i = 0; i < len; i++) k.text[8*i +: 8] = rand_key_char();
            clash = 1'b0;
            foreach (used_keys[j]) if (used_keys[j] == k) clash = 1'b1;
        end while (clash);
        return k;
    endfunction

    function automatic void put_key(key_t k);
        for (int i = 0; i < k.len; i++) put(k.text[8*i +: 8]);
    endfunction

    function automatic void put_pair(key_t k, int vlen);
        put_key(k);
        put(CH_EQ);
        put_value(vlen);
        put(CH_NL);
        used_keys.push_back(k);
    endfunction

    // returns 1 when the message must end right here
    function automatic bit put_fault();
        key_t   k;
        fault_e f;
        int     depth;
        k = fresh_key(key_len());
        f = fault_e'($urandom_range(0, F_KEY_NL));
        case (f)
            F_KEY_CHAR: begin
                repeat ($urandom_range(0, 3)) put(rand_key_char());
                put(non_key_byte());
            end
            F_KEY_LONG: begin
                put_key(fresh_key(KEY_MAX + 1));
                put(CH_EQ);
            end
            F_KEY_EMPTY: begin
                put(CH_EQ);
                put_value(2);
                put(CH_NL);
            end
            F_KEY_DUP: begin
                if (used_keys.size() > 0)
                    put_pair(used_keys[$urandom_range(0, used_keys.size() - 1)], 1);
            end
            F_ESC_HI: begin
                put_key(k);
                put(CH_EQ);
                put(CH_PCT);
                put(non_hex_byte());
                put(8'($urandom));
            end
            F_ESC_LO: begin
                put_key(k);
                put(CH_EQ);
                put(CH_PCT);
                put(hex_char(4'($urandom)));
                put(non_hex_byte());
            end
            F_RAW_CTL: begin
                put_key(k);
                put(CH_EQ);
                put(bad_value_char(1'b0));
            end
            F_ESC_CTL: begin
                put_key(k);
                put(CH_EQ);
                put_value_char(bad_value_char(1'b1), 1'b1);
            end
            F_CUT: begin
                put_key(k);
                depth = $urandom_range(0, 3);
                if (depth > 0) begin
                    put(CH_EQ);
                    put_value($urandom_range(0, 3));
                end
                if (depth > 1) put(CH_PCT);
                if (depth > 2) put(hex_char(4'($urandom)));
                return 1'b1;
            end
            F_NOISE: repeat ($urandom_range(1, 6)) put(8'($urandom));
            default: begin
                repeat ($urandom_range(0, 3)) put(rand_key_char());
                put(CH_NL);
            end
        endcase
        return 1'b0;
    endfunction

    // n pairs whose keys differ only in the last character
    function automatic void fill_pairs(int len, int n, int dup_of);
        key_t base;
        key_t k;
        base = fresh_key(len);
        for (int i = 0; i < n; i++) begin
            k = base;
            k.text[8*(len-1) +: 8] = key_char_at((i == n - 1 && dup_of >= 0) ? dup_of : i);
            put_key(k);
            put(CH_EQ);
            put_value($urandom_range(0, 2));
            put(CH_NL);
        end
    endfunction

    // request sender: bursts with random gaps
    task automatic send_item(t_in it);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 20);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(parse_byte(it));
        items_sent++;
    endtask

    task automatic send_message();
        while (body_bytes.size() > 0) send_item(body_bytes.pop_front());
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    task automatic random_message();
        int n;
        int fault_at;
        bit cut;
        n        = $urandom_range(0, 6);
        fault_at = ($urandom_range(0, 99) < 30) ? $urandom_range(0, n) : -1;
        cut      = 1'b0;
        for (int i = 0; i <= n && !cut; i++) begin
            if (i == fault_at) cut = put_fault();
            if (!cut && i < n) put_pair(fresh_key(key_len()), value_len());
        end
        put_end();
        send_message();
    endtask

    // receiver stall pattern, with a long hold-off on demand
    rx_mode_e    rx_mode   = RX_FREE;
    int          mode_left = 0;
    int          hold_left = 0;
    logic [31:0] stall_pat = '0;

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = rx_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 128);
                stall_pat = $urandom;
            end
            mode_left--;
            case (rx_mode)
                RX_FREE:    i_out_stall <= 1'b0;
                RX_PATTERN: begin
                    i_out_stall <= stall_pat[0];
                    stall_pat = {stall_pat[0], stall_pat[31:1]};
                end
                RX_LIGHT:   i_out_stall <= ($urandom_range(0, 3) == 0);
                default:    i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result %h", o_out_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_result(o_out_data, want);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles < WATCHDOG_LIMIT) begin
            quiet_cycles <= quiet_cycles + 1;
        end else begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic test_directed();
        put_end();
        put_text("a= ");
        put(8'hff);
        put(CH_NL);
        put_text("_9z=%7e");
        put(CH_NL);
        put_end();
        put_text("q");
        put_end();
        put(CH_EQ);
        put_end();
        put(CH_NL);
        put_end();
        put_text("x=%g1");
        put_end();
        send_message();
    endtask

    task automatic test_key_rules();
        key_t k;
        put_pair(fresh_key(KEY_MAX), 1);
        put_end();
        put_key(fresh_key(KEY_MAX + 1));
        put(CH_EQ);
        put_end();
        // length limit wins over a bad character
        put_key(fresh_key(KEY_MAX));
        put_text("!");
        put_end();
        put_text("ab");
        put(CH_NL);
        put_end();
        put_text("Ab=");
        put_end();
        put_pair(fresh_key(3), 1);
        put(CH_EQ);
        put_end();
        k = fresh_key(3);
        put_pair(k, 1);
        put_pair(fresh_key(3), 1);
        put_pair(k, 2);
        put_end();
        put_text("ab=1");
        put(CH_NL);
        put_text("abc=2");
        put(CH_NL);
        put_text("a=");
        put(CH_NL);
        put_end();
        put_key(fresh_key(4));
        put_end();
        send_message();
    endtask

    task automatic test_value_rules();
        string esc_cases [8] = '{"%00", "%7F", "%g1", "%4g", "%", "%4", "%0a", "%Ff"};
        put_key(fresh_key(2));
        put(CH_EQ);
        put_plain_value(VALUE_MAX);
        put_value_char(rand_value_char(), 1'b0);
        put_end();
        // bad character wins over the length limit
        put_key(fresh_key(2));
        put(CH_EQ);
        put_plain_value(VALUE_MAX);
        put(8'h01);
        put_end();
        foreach (esc_cases[i]) begin
            put_key(fresh_key(2));
            put(CH_EQ);
            put_text(esc_cases[i]);
            put_end();
        end
        put_key(fresh_key(1));
        put(CH_EQ);
        put_text("%fF%80 ~");
        put(CH_NL);
        put_end();
        put_key(fresh_key(1));
        put(CH_EQ);
        put(CH_DEL);
        put_end();
        put_key(fresh_key(1));
        put(CH_EQ);
        put(8'h1f);
        put_end();
        send_message();
    endtask

    task automatic test_pair_limit();
        fill_pairs(1, MAX_PAIRS, -1);
        put_text("z=1");
        put(CH_NL);
        put_end();
        // duplicate search over full-length keys sharing a prefix
        fill_pairs(KEY_MAX, 4, 2);
        put_end();
        send_message();
    endtask

    task automatic test_back_pressure();
        hold_req = 1'b1;
        repeat (2) random_message();
    endtask

    task automatic test_random();
        int target;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            random_message();
            if ($urandom_range(0, 9) == 0) wait_idle();
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        wait_idle();
        test_key_rules();
        wait_idle();
        test_value_rules();
        wait_idle();
        test_pair_limit();
        wait_idle();
        test_back_pressure();
        wait_idle();
        test_random();
        wait_idle();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
